FILE: src/srfr_pkg.sv
// Shared types, constants and the CRC step for the serial RTU frame receiver.
// No dependencies; every other file imports this package.
package srfr_pkg;

  localparam int unsigned BUFFER_DEPTH = 256;
  localparam int unsigned ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int unsigned CNT_W        = 9;

  localparam logic [7:0]  BROADCAST_ADDR = 8'h00;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TICK    = 2'd1,
    OP_READ    = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    EV_GOOD     = 3'd0,
    EV_CRC_BAD  = 3'd1,
    EV_SHORT    = 3'd2,
    EV_RX_ERROR = 3'd3,
    EV_READ     = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    REG_STATION    = 2'd0,
    REG_IDLE_TICKS = 2'd1,
    REG_GAP_TICKS  = 2'd2,
    REG_MIN_LENGTH = 2'd3
  } reg_t;

  typedef enum logic [4:0] {
    MODE_IDLE = 5'b00001,
    MODE_RECV = 5'b00010,
    MODE_FAIL = 5'b00100,
    MODE_SKIP = 5'b01000,
    MODE_HELD = 5'b10000
  } mode_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } item_t;

  typedef struct packed {
    logic [7:0]  station_address;
    logic [15:0] idle_ticks;
    logic [15:0] gap_ticks;
    logic [7:0]  min_length;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    event_t           kind;
    logic [CNT_W-1:0] length;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              in_range;
  } mem_req_t;

  // CRC-16 reflected, one byte folded in bit by bit
  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: src/serial_rtu_frame_receiver.sv
// Serial RTU frame receiver top level: request and result registers, config.
// Depends on srfr_pkg, srfr_framer and srfr_store.
//
// Requests (operation, rx_byte, read_index) enter on in_valid/in_stall: received
// bytes, timer ticks, reads of the frame store and release of a held frame.
// Results (event_kind, frame_length, read_byte) leave on out_valid/out_stall:
// one per read and one per frame that ends with a verdict; bytes, ticks,
// releases and a foreign frame's end give none.
// A request is taken into the request register, processed once the result
// register is free or being taken, and loaded into the result register at the
// closing edge of that cycle; throughput one request per cycle while no result
// waits under out_stall, set by the single framer pass and the store's one
// write and one registered read port.
// When out_stall holds a waiting result, processing halts and in_stall rises
// once the request register is full; nothing is lost.
// Reset (rst, synchronous) clears both registers, returns the framer to idle
// and loads station 1, idle 8 ticks, gap 4 ticks, minimum length 4. The store
// is not cleared; read only positions that a frame has written.
// Write config through cfg_write/cfg_index/cfg_data only while idle.
module serial_rtu_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_kind,
  output logic [8:0]  frame_length,
  output logic [7:0]  read_byte,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import srfr_pkg::*;

  cfg_t     cfg;
  logic     req_valid;
  item_t    req;
  logic     advance;
  logic     load;
  res_t     res;
  mem_req_t mem_req;
  logic [7:0] rdata;
  event_t     kind_q;
  logic       in_range_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.station_address <= 8'd1;
      cfg.idle_ticks      <= 16'd8;
      cfg.gap_ticks       <= 16'd4;
      cfg.min_length      <= 8'd4;
    end else if (cfg_write) begin
      case (reg_t'(cfg_index))
        REG_STATION:    cfg.station_address <= cfg_data[7:0];
        REG_IDLE_TICKS: cfg.idle_ticks      <= cfg_data;
        REG_GAP_TICKS:  cfg.gap_ticks       <= cfg_data;
        REG_MIN_LENGTH: cfg.min_length      <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // advance the request whenever the result register is free or being taken
  assign advance  = !out_valid || !out_stall;
  assign in_stall = req_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (load) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      req.operation  <= op_t'(operation);
      req.rx_byte    <= rx_byte;
      req.read_index <= read_index;
    end
  end

  srfr_framer u_framer (
    .clk     (clk),
    .rst     (rst),
    .go      (req_valid && advance),
    .item    (req),
    .cfg     (cfg),
    .res     (res),
    .mem_req (mem_req)
  );

  srfr_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      kind_q       <= res.kind;
      frame_length <= res.length;
      in_range_q   <= mem_req.in_range;
    end
  end

  assign event_kind = kind_q;
  assign read_byte  = (kind_q == EV_READ && in_range_q) ? rdata : 8'h00;

`ifndef ASSERT_OFF
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> req_valid && out_valid)
    else $error("request refused with room to spare");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(read_byte) && $stable(event_kind) &&
      $stable(frame_length))
    else $error("waiting result changed");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    req_valid && !out_valid |=> !req_valid || $past(load))
    else $error("request not processed with free result register");
`endif

endmodule

FILE: src/srfr_store.sv
// Frame byte store: one write port and one registered read port.
// Depends on srfr_pkg for the request struct and depth.
module srfr_store (
  input  logic               clk,
  input  srfr_pkg::mem_req_t req,
  output logic [7:0]         rdata
);
  import srfr_pkg::*;

  logic [7:0] mem [BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

FILE: src/srfr_framer.sv
// Frame state machine: silence timing, byte counting, CRC and frame verdicts.
// Depends on srfr_pkg; drives store requests and at most one result per request.
module srfr_framer (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  srfr_pkg::item_t    item,
  input  srfr_pkg::cfg_t     cfg,
  output srfr_pkg::res_t     res,
  output srfr_pkg::mem_req_t mem_req
);
  import srfr_pkg::*;

  mode_t            mode, mode_next;
  logic [15:0]      silence, silence_next;
  logic [CNT_W-1:0] count, count_next;
  logic [15:0]      crc, crc_next;

  logic room;
  logic gap_ok;

  assign room   = count < CNT_W'(BUFFER_DEPTH);
  assign gap_ok = silence < cfg.gap_ticks;

  always_comb begin
    mode_next    = mode;
    silence_next = silence;
    count_next   = count;
    crc_next     = crc;
    res.valid    = 1'b0;
    res.kind     = EV_READ;
    res.length   = count;
    mem_req.we       = 1'b0;
    mem_req.waddr    = count[ADDR_W-1:0];
    mem_req.wdata    = item.rx_byte;
    mem_req.re       = 1'b0;
    mem_req.raddr    = item.read_index[ADDR_W-1:0];
    mem_req.in_range = {1'b0, item.read_index} < CNT_W'(BUFFER_DEPTH);

    if (go) begin
      case (item.operation)
        OP_BYTE: begin
          silence_next = '0;
          if (mode == MODE_IDLE && count == '0) begin
            if (item.rx_byte == cfg.station_address || item.rx_byte == BROADCAST_ADDR) begin
              mode_next  = MODE_RECV;
              mem_req.we = 1'b1;
              count_next = CNT_W'(1);
              crc_next   = crc_fold(CRC_INIT, item.rx_byte);
            end else begin
              mode_next = MODE_SKIP;
            end
          end else if (mode == MODE_RECV) begin
            if (room && gap_ok) begin
              mem_req.we = 1'b1;
              crc_next   = crc_fold(crc, item.rx_byte);
            end else begin
              mode_next = MODE_FAIL;
            end
            if (room) begin
              count_next = count + CNT_W'(1);
            end
          end
        end
        OP_TICK: begin
          if (mode inside {MODE_RECV, MODE_FAIL, MODE_SKIP}) begin
            if (silence < cfg.idle_ticks) begin
              silence_next = silence + 16'd1;
            end else begin
              // frame over: return to idle unless a good frame is held
              mode_next  = MODE_IDLE;
              count_next = '0;
              crc_next   = CRC_INIT;
              if (mode == MODE_FAIL) begin
                res.valid = 1'b1;
                res.kind  = EV_RX_ERROR;
              end else if (mode == MODE_RECV) begin
                res.valid = 1'b1;
                if (count <= {1'b0, cfg.min_length}) begin
                  res.kind = EV_SHORT;
                end else if (crc == 16'h0000) begin
                  res.kind   = EV_GOOD;
                  mode_next  = MODE_HELD;
                  count_next = count;
                  crc_next   = crc;
                end else begin
                  res.kind = EV_CRC_BAD;
                end
              end
            end
          end
        end
        OP_READ: begin
          res.valid  = 1'b1;
          res.kind   = EV_READ;
          mem_req.re = 1'b1;
        end
        OP_RELEASE: begin
          if (mode == MODE_HELD) begin
            mode_next  = MODE_IDLE;
            count_next = '0;
            crc_next   = CRC_INIT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      silence <= '0;
      count   <= '0;
      crc     <= CRC_INIT;
    end else begin
      mode    <= mode_next;
      silence <= silence_next;
      count   <= count_next;
      crc     <= crc_next;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(BUFFER_DEPTH))
    else $error("byte count beyond buffer depth");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_IDLE |-> count == '0 && crc == CRC_INIT)
    else $error("idle with stale count or CRC");

  a_good_held: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind == EV_GOOD |=> mode == MODE_HELD)
    else $error("good frame not held");

  a_write_mode: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> mode == MODE_IDLE || mode == MODE_RECV)
    else $error("store written outside reception");
`endif

endmodule

FILE: sim/serial_rtu_frame_receiver_tb.sv
// Testbench for serial_rtu_frame_receiver: directed frames, then random frames and noise
// under several register settings, each result checked against a behavioural predictor.
// Depends on srfr_pkg and the RTL in src; needs nothing else.
`timescale 1ns / 100ps

module serial_rtu_frame_receiver_tb;
  import srfr_pkg::*;

  localparam int ITEM_BUDGET    = 1950;
  localparam int STUCK_LIMIT    = 4000;
  localparam int HOLDOFF_CYCLES = 200;

  typedef struct {
    event_t     kind;
    logic [8:0] length;
    logic [7:0] data;
  } frame_event_t;

  class rtu_frame_scoreboard;
    logic [7:0]   station;
    logic [15:0]  idle_limit;
    logic [15:0]  gap_limit;
    logic [7:0]   min_len;
    mode_t        mode;
    logic [15:0]  silence;
    logic [8:0]   count;
    logic [15:0]  crc;
    logic [7:0]   store [BUFFER_DEPTH];
    bit           written [BUFFER_DEPTH];
    int           written_idx [$];
    frame_event_t pending_events [$];
    int           errors;
    int           requests_seen;
    int           results_seen;
    int           kind_seen [5];

    function new();
      station    = 8'd1;
      idle_limit = 16'd8;
      gap_limit  = 16'd4;
      min_len    = 8'd4;
      mode       = MODE_IDLE;
      silence    = '0;
      count      = '0;
      crc        = 16'hFFFF;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    // reflected CRC-16, fed one data bit at a time, LSB first
    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ b[i];
        c  = c >> 1;
        if (fb) c = c ^ 16'hA001;
      end
      return c;
    endfunction

    function void set_reg(reg_t r, logic [15:0] v);
      case (r)
        REG_STATION:    station    = v[7:0];
        REG_IDLE_TICKS: idle_limit = v;
        REG_GAP_TICKS:  gap_limit  = v;
        REG_MIN_LENGTH: min_len    = v[7:0];
        default: begin
        end
      endcase
    endfunction

    function void keep(logic [7:0] idx, logic [7:0] b);
      store[idx] = b;
      if (!written[idx]) begin
        written[idx] = 1'b1;
        written_idx.push_back(idx);
      end
    endfunction

    function void rearm();
      mode  = MODE_IDLE;
      count = '0;
      crc   = 16'hFFFF;
    endfunction

    function void await_event(event_t kind, logic [8:0] len, logic [7:0] data);
      frame_event_t ev;
      ev.kind   = kind;
      ev.length = len;
      ev.data   = data;
      pending_events.push_back(ev);
    endfunction

    function void end_frame();
      if (mode == MODE_SKIP) begin
        rearm();
      end else if (mode == MODE_FAIL) begin
        await_event(EV_RX_ERROR, count, 8'h00);
        rearm();
      end else if (count <= min_len) begin
        await_event(EV_SHORT, count, 8'h00);
        rearm();
      end else if (crc == 16'h0000) begin
        // good frame stays held until released
        mode = MODE_HELD;
        await_event(EV_GOOD, count, 8'h00);
      end else begin
        await_event(EV_CRC_BAD, count, 8'h00);
        rearm();
      end
    endfunction

    // advance the framer by one accepted request
    function void take_request(op_t op, logic [7:0] b, logic [7:0] idx);
      bit gap_ok;
      requests_seen++;
      case (op)
        OP_BYTE: begin
          // gap is judged on the silence before this byte
          gap_ok  = silence < gap_limit;
          silence = '0;
          if (mode == MODE_IDLE && count == 0) begin
            if (b == station || b == BROADCAST_ADDR) begin
              mode  = MODE_RECV;
              keep(8'd0, b);
              count = 9'd1;
              crc   = crc_step(16'hFFFF, b);
            end else begin
              mode = MODE_SKIP;
            end
          end else if (mode == MODE_RECV) begin
            if (count < BUFFER_DEPTH && gap_ok) begin
              keep(count[7:0], b);
              crc = crc_step(crc, b);
            end else begin
              mode = MODE_FAIL;
            end
            if (count < BUFFER_DEPTH) count++;
          end
        end
        OP_TICK: begin
          if (mode inside {MODE_RECV, MODE_FAIL, MODE_SKIP}) begin
            if (silence < idle_limit) silence++;
            else end_frame();
          end
        end
        OP_READ: await_event(EV_READ, count, store[idx]);
        OP_RELEASE: begin
          if (mode == MODE_HELD) rearm();
        end
        default: begin
        end
      endcase
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_event(logic [2:0] kind, logic [8:0] len, logic [7:0] data);
      frame_event_t want;
      results_seen++;
      if (pending_events.size() == 0) begin
        report($sformatf("unexpected result kind %0d length %0d data %02h", kind, len, data));
        return;
      end
      want = pending_events.pop_front();
      kind_seen[want.kind]++;
      if (kind !== want.kind || len !== want.length || data !== want.data)
        report($sformatf("result %0d: got kind %0d length %0d data %02h, want %0d %0d %02h",
                         results_seen, kind, len, data, want.kind, want.length, want.data));
    endtask
  endclass

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [1:0]  operation    = '0;
  logic [7:0]  rx_byte      = '0;
  logic [7:0]  read_index   = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [2:0]  event_kind;
  logic [8:0]  frame_length;
  logic [7:0]  read_byte;
  logic        cfg_write    = 1'b0;
  logic [1:0]  cfg_index    = '0;
  logic [15:0] cfg_data     = '0;

  rtu_frame_scoreboard sb;
  int items_sent    = 0;
  int settings_done = 0;
  bit steady        = 1'b0;
  bit holdoff_req   = 1'b0;

  serial_rtu_frame_receiver dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_event(event_kind, frame_length, read_byte);
  end

  // result side: random stalls, quiet stretches, and one long hold-off on request
  initial begin : result_stall
    int len;
    int r;
    bit hold;
    @(posedge clk);
    forever begin
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        hold = 1'b1;
        len  = HOLDOFF_CYCLES;
      end else if (steady) begin
        hold = 1'b0;
        len  = 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          hold = 1'b0;
          len  = $urandom_range(1, 20);
        end else begin
          hold = 1'b1;
          if (r < 90) len = $urandom_range(1, 3);
          else if (r < 98) len = $urandom_range(4, 12);
          else len = $urandom_range(30, 80);
        end
      end
      out_stall <= hold;
      repeat (len) @(posedge clk);
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("watchdog: nothing moved for %0d cycles", STUCK_LIMIT);
    $display("FAIL");
    $finish;
  end

  function automatic int sender_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] random_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int stored_index();
    if (sb.written_idx.size() == 0) return -1;
    return sb.written_idx[$urandom_range(0, sb.written_idx.size() - 1)];
  endfunction

  function automatic logic [7:0] frame_address();
    int r;
    logic [7:0] a;
    r = $urandom_range(0, 9);
    if (r < 6) return sb.station;
    if (r < 8) return BROADCAST_ADDR;
    do a = 8'($urandom_range(1, 255)); while (a == sb.station);
    return a;
  endfunction

  // called at a clock edge; returns at the edge where the request was taken
  task automatic send_item(op_t op, logic [7:0] b, logic [7:0] idx);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    rx_byte    <= b;
    read_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_request(op, b, idx);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(OP_BYTE, b, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic send_read(logic [7:0] idx);
    send_item(OP_READ, 8'($urandom_range(0, 255)), idx);
  endtask

  task automatic send_release();
    send_item(OP_RELEASE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // drop valid and hold until every result is in, plus the pipeline latency
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_t r, logic [15:0] v);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    sb.set_reg(r, v);
  endtask

  task automatic configure(logic [7:0] st, logic [15:0] idle_t, logic [15:0] gap_t,
                           logic [7:0] min_l);
    wait_drained();
    write_reg(REG_STATION, {8'h00, st});
    write_reg(REG_IDLE_TICKS, idle_t);
    write_reg(REG_GAP_TICKS, gap_t);
    write_reg(REG_MIN_LENGTH, {8'h00, min_l});
    cfg_write <= 1'b0;
    settings_done++;
  endtask

  // address, body bytes, optional CRC seal; broken puts a too-long gap before one byte
  task automatic send_frame(logic [7:0] addr, int body, bit seal, bit broken);
    logic [15:0] c;
    logic [7:0]  b;
    int          total;
    int          ticks;
    int          break_at;
    total    = 1 + body + (seal ? 2 : 0);
    break_at = (broken && total > 1 && sb.gap_limit <= 16) ? $urandom_range(1, total - 1) : -1;
    c = sb.crc_step(16'hFFFF, addr);
    send_byte(addr);
    for (int i = 1; i < total; i++) begin
      if (i == break_at) begin
        ticks = int'(sb.gap_limit);
      end else begin
        ticks = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
        if (ticks > int'(sb.gap_limit) - 1) ticks = int'(sb.gap_limit) - 1;
        if (ticks > int'(sb.idle_limit)) ticks = int'(sb.idle_limit);
      end
      repeat (ticks) send_tick();
      if (i <= body) begin
        b = random_byte();
        c = sb.crc_step(c, b);
      end else if (i == body + 1) begin
        b = c[7:0];
      end else begin
        b = c[15:8];
      end
      send_byte(b);
    end
  endtask

  // tick until the current frame has ended
  task automatic close_frame();
    while (sb.mode inside {MODE_RECV, MODE_FAIL, MODE_SKIP}) send_tick();
  endtask

  task automatic serve_held_frame();
    int r;
    repeat ($urandom_range(0, 4)) begin
      r = $urandom_range(0, 9);
      if (r < 6) send_read(8'($urandom_range(0, sb.count - 1)));
      else if (r < 8) send_byte(random_byte());
      else send_tick();
    end
    if ($urandom_range(0, 9) < 8) send_release();
  endtask

  task automatic run_phase(int quota);
    int stop_at;
    int body;
    int idx;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      steady = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 99) < 75) begin
        body = ($urandom_range(0, 49) == 0) ? $urandom_range(250, 258) : $urandom_range(0, 9);
        send_frame(frame_address(), body, $urandom_range(0, 9) < 7, $urandom_range(0, 9) == 0);
        // now and then run straight into the next frame without the idle gap
        if ($urandom_range(0, 9) != 0) close_frame();
        if (sb.mode == MODE_HELD) serve_held_frame();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0: send_byte(random_byte());
            1: send_tick();
            2: begin
              idx = stored_index();
              if (idx >= 0) send_read(idx[7:0]);
              else send_tick();
            end
            default: send_release();
          endcase
        end
      end
    end
    steady = 1'b0;
    close_frame();
    if (sb.mode == MODE_HELD) send_release();
  endtask

  task automatic directed_checks();
    logic [15:0] c;
    configure(8'd247, 16'd1, 16'd1, 8'd2);
    send_tick();
    send_release();
    // good frame with extreme data bytes, sealed with its CRC
    c = sb.crc_step(sb.crc_step(sb.crc_step(16'hFFFF, 8'd247), 8'h00), 8'hFF);
    send_byte(8'd247);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(c[7:0]);
    send_byte(c[15:8]);
    send_tick();
    send_tick();
    send_read(8'd0);
    send_read(8'd4);
    send_byte(8'h55);
    send_release();
    // broadcast frame too short
    send_byte(BROADCAST_ADDR);
    send_byte(8'h42);
    send_tick();
    send_tick();
    // foreign address: frame skipped silently
    send_byte(8'h01);
    send_tick();
    send_tick();
    // tick between bytes breaks the gap limit
    send_byte(8'd247);
    send_tick();
    send_byte(8'h03);
    send_tick();
    send_tick();
    // unsealed frame: CRC bad
    send_byte(8'd247);
    send_byte(8'h01);
    send_byte(8'h02);
    send_tick();
    send_tick();
  endtask

  // hold the result side off while reads keep coming, so the block backs up
  task automatic stall_burst();
    int idx;
    in_valid    <= 1'b0;
    holdoff_req = 1'b1;
    // wait until the hold-off has actually started
    while (holdoff_req) @(posedge clk);
    steady      = 1'b1;
    repeat (16) begin
      idx = stored_index();
      send_read(idx[7:0]);
    end
    steady = 1'b0;
  endtask

  task automatic long_frames();
    // exactly a full buffer, sealed: the only length that beats min_length 255
    send_frame(sb.station, 253, 1'b1, 1'b0);
    close_frame();
    send_read(8'd255);
    send_read(8'd128);
    send_release();
    // two bytes beyond the buffer: overflow, count saturates
    send_frame(sb.station, 257, 1'b0, 1'b0);
    close_frame();
  endtask

  // long gap inside a frame under a wide gap limit, then a long idle count to end it
  task automatic slow_frame();
    steady = 1'b1;
    send_byte(sb.station);
    send_byte(8'h10);
    repeat (60) send_tick();
    send_byte(8'h20);
    close_frame();
    steady = 1'b0;
  endtask

  initial begin : stimulus
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_checks();
    stall_burst();
    configure(8'd1, 16'd8, 16'd4, 8'd4);
    run_phase(150);
    // let the sender sit until every result has come back
    wait_drained();
    run_phase(150);
    configure(8'd247, 16'd1, 16'd1, 8'd0);
    run_phase(250);
    configure(8'($urandom_range(2, 246)), 16'd3, 16'hFFFF, 8'd255);
    long_frames();
    run_phase(150);
    configure(8'd1, 16'd100, 16'hFFFF, 8'd0);
    slow_frame();
    while (items_sent < ITEM_BUDGET) begin
      configure(8'($urandom_range(1, 247)), 16'($urandom_range(1, 12)),
                16'($urandom_range(1, 12)), 8'($urandom_range(0, 10)));
      run_phase(250);
    end
    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.pending_events.size() != 0) sb.report("results still outstanding at end of run");
    $display("covered %0d requests over %0d register settings; %0d results checked",
             sb.requests_seen, settings_done, sb.results_seen);
    $display("outcomes: %0d good, %0d crc bad, %0d short, %0d receive error, %0d reads",
             sb.kind_seen[EV_GOOD], sb.kind_seen[EV_CRC_BAD], sb.kind_seen[EV_SHORT],
             sb.kind_seen[EV_RX_ERROR], sb.kind_seen[EV_READ]);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
